/* rtl/core/bmnp_pkg.sv */
`timescale 1ns / 1ps

package bmnp_pkg;

    localparam int WORD_COUNT = 64;
    localparam int WORD_BITS  = 64;
    localparam int IDX_W      = 12;
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int BOFS_W     = $clog2(WORD_BITS);
    localparam int LEFT_W     = WADDR_W + 1;

    // operation codes
    localparam logic [2:0] K_READ    = 3'd0;
    localparam logic [2:0] K_SET     = 3'd1;
    localparam logic [2:0] K_CLEAR   = 3'd2;
    localparam logic [2:0] K_NEXT    = 3'd3;
    localparam logic [2:0] K_PREV    = 3'd4;
    localparam logic [2:0] K_CLR_ALL = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] bit_index;
    } t_in_item;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] position;
        logic [1:0]       status;
    } t_out_item;

    // lowest set bit, binary search over halves (6 steps)
    function automatic logic [BOFS_W-1:0] low_one(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] lmask;
        logic [BOFS_W-1:0]    r;
        v = w;
        r = '0;
        for (int k = BOFS_W - 1; k >= 0; k--) begin
            lmask = {WORD_BITS{1'b1}} >> (WORD_BITS - (1 << k));
            if ((v & lmask) == '0) begin
                r[k] = 1'b1;
                v    = v >> (1 << k);
            end else begin
                v = v & lmask;
            end
        end
        return r;
    endfunction

    // highest set bit, binary search over halves (6 steps)
    function automatic logic [BOFS_W-1:0] high_one(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] lmask;
        logic [BOFS_W-1:0]    r;
        v = w;
        r = '0;
        for (int k = BOFS_W - 1; k >= 0; k--) begin
            lmask = {WORD_BITS{1'b1}} >> (WORD_BITS - (1 << k));
            if ((v >> (1 << k)) != '0) begin
                r[k] = 1'b1;
                v    = v >> (1 << k);
            end else begin
                v = v & lmask;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/bitmap_next_prev_set_bit.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_ready  | i_item   (kind, bit_index)
// result  | out       | o_valid / i_ready  | o_result (bit_value, position, status)
// config  | in        | APB psel/penable   | pwdata[11:0] -> bits_in_use at paddr 0
//
// Path through the sequencer states, from acceptance to S_DONE:
// read, set, clear, and a search that hits in the index's own word pass S_EVAL;
// clear-all, unused kinds and out-of-range items go straight to S_DONE. A search
// that scans adds S_SCAN, which reads words until a hit, at most 63 words (no
// hit): the single memory read port delivers one word per cycle.
// Reset (synchronous, active low) clears the per-word valid bits at once, so the
// store reads as zero with no clearing pass; clear-all does the same.
// o_ready is high only when no item is in work; a result waiting on i_ready
// holds the finished item in the output register and does not block acceptance.
module bitmap_next_prev_set_bit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bmnp_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output bmnp_pkg::t_out_item   o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import bmnp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // ---------------- configuration ----------------
    logic [IDX_W-1:0] r_bits_in_use;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-IDX_W){1'b0}}, r_bits_in_use} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_bits_in_use <= pwdata[IDX_W-1:0];
        end
    end

    // ---------------- word store ----------------
    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_wvalid;     // word written since last clear
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  r_rvld;
    logic                  mem_re;
    logic [WADDR_W-1:0]    mem_raddr;
    logic                  mem_we;
    logic [WADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  clr_all;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_rvld   <= 1'b0;
        end else begin
            if (clr_all) begin
                r_wvalid <= '0;
            end else if (mem_we) begin
                r_wvalid[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                r_rvld <= r_wvalid[mem_raddr];
            end
        end
    end

    // ---------------- sequencer ----------------
    logic [1:0]          r_state, n_state;
    logic [2:0]          r_kind, n_kind;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [WADDR_W-1:0]  r_ptr, n_ptr;      // next word to read in scan
    logic [WADDR_W-1:0]  r_pptr, n_pptr;    // word whose data is in r_rdata
    logic [LEFT_W-1:0]   r_left, n_left;    // words still to read
    logic                r_pend, n_pend;
    t_out_item           r_res, n_res;
    logic                r_oval, n_oval;
    t_out_item           r_out, n_out;

    logic                accept;
    logic [WORD_BITS-1:0] eff;
    logic [WADDR_W-1:0]  word;
    logic [BOFS_W-1:0]   sh;
    logic [WADDR_W-1:0]  last;
    logic [WORD_BITS-1:0] mnext, mprev, bitm;
    logic                scan_up;
    logic                out_free;
    logic [IDX_W-1:0]    in_idx;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_oval;
    assign o_result = r_out;
    assign out_free = !r_oval || i_ready;
    assign in_idx   = i_item.bit_index;

    assign eff     = r_rvld ? r_rdata : '0;
    assign word    = r_idx[IDX_W-1:BOFS_W];
    assign sh      = r_idx[BOFS_W-1:0];
    assign last    = r_bits_in_use[IDX_W-1:BOFS_W];
    assign bitm    = {{(WORD_BITS-1){1'b0}}, 1'b1} << sh;
    assign mnext   = eff & ({WORD_BITS{1'b1}} << sh);
    assign mprev   = eff & ({WORD_BITS{1'b1}} >> (BOFS_W'(WORD_BITS - 1) - sh));
    assign scan_up = (r_kind == K_NEXT);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_ptr     = r_ptr;
        n_pptr    = r_pptr;
        n_left    = r_left;
        n_pend    = r_pend;
        n_res     = r_res;
        n_oval    = r_oval;
        n_out     = r_out;
        mem_re    = 1'b0;
        mem_raddr = in_idx[IDX_W-1:BOFS_W];
        mem_we    = 1'b0;
        mem_waddr = word;
        mem_wdata = eff;
        clr_all   = 1'b0;

        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_item.kind;
                    n_idx  = in_idx;
                    n_res  = '{bit_value: 1'b0, position: '0, status: ST_OK};
                    mem_re = 1'b1;
                    if (i_item.kind == K_CLR_ALL) begin
                        clr_all = 1'b1;
                        n_state = S_DONE;
                    end else if (i_item.kind > K_PREV) begin
                        n_state = S_DONE;
                    end else if ((in_idx >= r_bits_in_use) ||
                                 ({1'b0, in_idx[IDX_W-1:BOFS_W]} >= LEFT_W'(WORD_COUNT))) begin
                        n_res.status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                n_pend  = 1'b0;
                priority if (r_kind == K_READ) begin
                    n_res.bit_value = eff[sh];
                end else if (r_kind == K_SET) begin
                    mem_we    = 1'b1;
                    mem_wdata = eff | bitm;
                end else if (r_kind == K_CLEAR) begin
                    mem_we    = 1'b1;
                    mem_wdata = eff & ~bitm;
                end else if (r_kind == K_NEXT) begin
                    if (mnext != '0) begin
                        n_res.position = {word, low_one(mnext)};
                    end else begin
                        n_ptr   = word + WADDR_W'(1);
                        n_left  = (last > word) ? LEFT_W'(last - word) : '0;
                        n_state = S_SCAN;
                    end
                end else begin
                    if (mprev != '0) begin
                        n_res.position = {word, high_one(mprev)};
                    end else begin
                        n_ptr   = word - WADDR_W'(1);
                        n_left  = {1'b0, word};
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                mem_raddr = r_ptr;
                if (r_pend && (eff != '0)) begin
                    n_res.position = scan_up ? {r_pptr, low_one(eff)}
                                             : {r_pptr, high_one(eff)};
                    n_state        = S_DONE;
                end else if (r_left != '0) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pptr = r_ptr;
                    n_left = r_left - LEFT_W'(1);
                    n_ptr  = scan_up ? r_ptr + WADDR_W'(1) : r_ptr - WADDR_W'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_res.position = r_bits_in_use;
                    n_res.status   = ST_NONE;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_pend  <= n_pend;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_ptr  <= n_ptr;
        r_pptr <= n_pptr;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // ---------------- assertions ----------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("item accepted while another is in work");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.kind == K_CLR_ALL) |=> (r_wvalid == '0))
        else $error("clear-all left written words");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_up && r_left != '0) |-> (r_ptr <= last))
        else $error("upward scan past last word in use");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_RANGE) |->
            (o_result.position == '0 && !o_result.bit_value))
        else $error("out-of-range result carries data");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("store written during a search");

endmodule

/* tb/sv/tb_bitmap_next_prev_set_bit.sv */
`timescale 1ns / 1ps

module tb_bitmap_next_prev_set_bit;
    import bmnp_pkg::*;

    // kinds the block must pass through untouched
    localparam logic [2:0] K_UNUSED_6 = 3'd6;
    localparam logic [2:0] K_UNUSED_7 = 3'd7;
    // register map: bits_in_use is register 0
    localparam logic [2:0] REG_BITS_IN_USE = 3'd0;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;     // longest search plus margin
    localparam int STALL_AT     = 150;    // long receiver hold-off starts here
    localparam int STALL_LEN    = 400;
    localparam int QUIET_FROM   = 300;    // no idling on either side in this window
    localparam int QUIET_TO     = 400;

    // Bit-vector predictor: own copy of the word store and of the length,
    // plus the queue of results still owed by the block.
    class bitmap_scoreboard;
        logic [WORD_BITS-1:0] words [WORD_COUNT];
        logic [IDX_W-1:0]     length;
        t_out_item            owed [$];
        int                   errors;
        int                   accepted;
        int                   checked;

        function new();
            wipe();
            length   = '0;
            errors   = 0;
            accepted = 0;
            checked  = 0;
        endfunction

        function void wipe();
            foreach (words[i]) words[i] = '0;
        endfunction

        function void set_length(logic [IDX_W-1:0] len);
            length = len;
        endfunction

        function void report(string msg);
            if (errors < 40) $display("mismatch: %s", msg);
            errors++;
        endfunction

        // work out the single result caused by one accepted item
        function void note_item(t_in_item it);
            t_out_item exp;
            int        b;
            int        top;
            exp.bit_value = 1'b0;
            exp.position  = '0;
            exp.status    = ST_OK;
            accepted++;
            if (it.kind == K_CLR_ALL) begin
                wipe();
            end else if (it.kind <= K_PREV) begin
                if (it.bit_index >= length) begin
                    exp.status = ST_RANGE;
                end else begin
                    case (it.kind)
                        K_READ: begin
                            exp.bit_value = words[it.bit_index[11:6]][it.bit_index[5:0]];
                        end
                        K_SET: begin
                            words[it.bit_index[11:6]][it.bit_index[5:0]] = 1'b1;
                        end
                        K_CLEAR: begin
                            words[it.bit_index[11:6]][it.bit_index[5:0]] = 1'b0;
                        end
                        K_NEXT: begin
                            // scan covers whole words up to word length>>6, so stale
                            // bits past the length can still be found
                            top = (int'(length >> 6) + 1) * WORD_BITS;
                            exp.position = length;
                            exp.status   = ST_NONE;
                            for (b = int'(it.bit_index); b < top; b++) begin
                                if (words[b / WORD_BITS][b % WORD_BITS]) begin
                                    exp.position = IDX_W'(b);
                                    exp.status   = ST_OK;
                                    break;
                                end
                            end
                        end
                        default: begin
                            exp.position = length;
                            exp.status   = ST_NONE;
                            for (b = int'(it.bit_index); b >= 0; b--) begin
                                if (words[b / WORD_BITS][b % WORD_BITS]) begin
                                    exp.position = IDX_W'(b);
                                    exp.status   = ST_OK;
                                    break;
                                end
                            end
                        end
                    endcase
                end
            end
            owed.push_back(exp);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (owed.size() == 0) begin
                report($sformatf("result %0d arrived with nothing owed", checked));
            end else begin
                exp = owed.pop_front();
                if (got.bit_value !== exp.bit_value)
                    report($sformatf("result %0d bit_value got %b want %b",
                                     checked, got.bit_value, exp.bit_value));
                if (got.position !== exp.position)
                    report($sformatf("result %0d position got %0d want %0d",
                                     checked, got.position, exp.position));
                if (got.status !== exp.status)
                    report($sformatf("result %0d status got %0d want %0d",
                                     checked, got.status, exp.status));
            end
            checked++;
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_item  = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    bitmap_scoreboard sb;
    int cycles         = 0;
    int rx_items       = 0;   // input handshakes seen by the receiver process
    int stall_left     = 0;
    bit stall_done     = 1'b0;

    bitmap_next_prev_set_bit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: checks every accepted result and drives i_ready.
    // All sampling uses pre-edge values, so ordering within the step is moot.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) sb.check_result(o_result);
            if (i_valid && o_ready) rx_items++;
            // one long hold-off while the sender keeps offering items
            if (!stall_done && rx_items >= STALL_AT) begin
                stall_left = STALL_LEN;
                stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (rx_items >= QUIET_FROM && rx_items < QUIET_TO) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    function automatic t_in_item make_item(logic [2:0] kind, logic [IDX_W-1:0] idx);
        t_in_item it;
        it.kind      = kind;
        it.bit_index = idx;
        return it;
    endfunction

    // Mostly in-range set/clear/read/search traffic; a little noise:
    // clear-all, unused kinds and indexes anywhere in the field.
    function automatic t_in_item pick_item(logic [IDX_W-1:0] len);
        int       r;
        t_in_item it;
        r = $urandom_range(0, 99);
        it.bit_index = (len == 0) ? IDX_W'($urandom_range(0, 4095))
                                  : IDX_W'($urandom_range(0, int'(len) - 1));
        if (r < 30)      it.kind = K_SET;
        else if (r < 40) it.kind = K_CLEAR;
        else if (r < 54) it.kind = K_READ;
        else if (r < 71) it.kind = K_NEXT;
        else if (r < 88) it.kind = K_PREV;
        else if (r < 90) it.kind = K_CLR_ALL;
        else if (r < 93) it.kind = ($urandom_range(0, 1) != 0) ? K_UNUSED_7 : K_UNUSED_6;
        else begin
            it.kind      = 3'($urandom_range(0, 4));
            it.bit_index = IDX_W'($urandom_range(0, 4095));
        end
        return it;
    endfunction

    // valid stays up across back-to-back items; it is only lowered for a gap
    task automatic send_item(input t_in_item it);
        while (!(sb.accepted >= QUIET_FROM && sb.accepted < QUIET_TO)
               && $urandom_range(0, 99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // APB write of bits_in_use, then a read-back
    task automatic config_length(input logic [IDX_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BITS_IN_USE;
        pwdata  <= {20'd0, len};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_length(len);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[IDX_W-1:0] !== len)
            sb.report($sformatf("bits_in_use read back %0d want %0d",
                                prdata[IDX_W-1:0], len));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_items();
        // empty vector: every indexed operation is out of range
        config_length(12'd0);
        send_item(make_item(K_READ, 12'd0));
        send_item(make_item(K_NEXT, 12'd4095));
        send_item(make_item(K_UNUSED_7, 12'd0));
        wait_drained();
        // full length: corners of the index field, word borders
        config_length(12'd4095);
        send_item(make_item(K_SET, 12'd0));
        send_item(make_item(K_SET, 12'd63));
        send_item(make_item(K_SET, 12'd64));
        send_item(make_item(K_SET, 12'd4094));
        send_item(make_item(K_READ, 12'd0));
        send_item(make_item(K_READ, 12'd1));
        send_item(make_item(K_NEXT, 12'd1));
        send_item(make_item(K_NEXT, 12'd65));     // long upward scan
        send_item(make_item(K_PREV, 12'd4093));   // long downward scan
        send_item(make_item(K_PREV, 12'd62));
        send_item(make_item(K_PREV, 12'd0));
        send_item(make_item(K_NEXT, 12'd4094));
        send_item(make_item(K_READ, 12'd4095));   // index equal to length
        send_item(make_item(K_SET, 12'd4095));
        send_item(make_item(K_CLEAR, 12'd0));
        send_item(make_item(K_PREV, 12'd62));     // nothing below
        send_item(make_item(K_UNUSED_6, 12'hABC));
        send_item(make_item(K_CLR_ALL, 12'd4095));
        send_item(make_item(K_NEXT, 12'd0));      // empty store
        send_item(make_item(K_PREV, 12'd4094));
        send_item(make_item(K_READ, 12'd64));
        wait_drained();
    endtask

    task automatic random_phase(input int count, input logic [IDX_W-1:0] len);
        config_length(len);
        repeat (count) send_item(pick_item(len));
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();

        // populate a long vector; the receiver hold-off lands here
        random_phase(200, 12'd4095);
        // shrink without clearing: stale bits past the length stay findable
        random_phase(80, 12'd150);
        random_phase(25, 12'd1);
        // quiet window (no idling) falls across these
        random_phase(60, 12'd64);
        random_phase(80, IDX_W'($urandom_range(2, 4094)));
        random_phase(80, 12'd4095);
        random_phase(15, 12'd0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bmnp_pkg.sv
rtl/core/bitmap_next_prev_set_bit.sv
tb/sv/tb_bitmap_next_prev_set_bit.sv
